@@ hw/rtl/chm_pkg.sv @@
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants for the chained hash map engine: command codes,
// controller states, result selection and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package chm_pkg;

    // default sizes
    localparam int DEF_MAX_BUCKETS  = 1024;
    localparam int DEF_POOL_ENTRIES = 1024;

    // field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 63;
    localparam int HANDLE_W = 32;
    localparam int LEVEL_W  = 16;
    localparam int BC_W     = 11;
    localparam int IV_W     = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // serial divider
    localparam int DIV_W     = 64;
    localparam int DVS_W     = 32;
    localparam int DIV_CNT_W = 7;

    localparam logic [DIV_W-1:0] HASH_OFFSET = 64'd84751;
    localparam logic [BC_W-1:0]  BC_RESET    = 11'd1024;
    localparam logic [IV_W-1:0]  IV_RESET    = 32'd1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKET_COUNT = 1'b0,
        CFG_KEY_INTERVAL = 1'b1
    } cfg_idx_t;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_SET    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // result selection
    typedef enum logic [2:0] {
        RES_NONE,
        RES_VALUE,
        RES_DEFAULT,
        RES_FOUND,
        RES_FULL
    } res_t;

    // controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SWEEP,
        ST_DIVQ,
        ST_DIVR,
        ST_HEAD,
        ST_HEADW,
        ST_WALK,
        ST_CMP,
        ST_INSERT,
        ST_RELEASE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_sel;
        logic bucket_save;
        logic head_rd;
        logic head_load;
        logic ent_rd;
        logic adv;
        logic upd_write;
        logic free_rd;
        logic ins_write;
        logic unlink;
        logic release_ent;
        logic sweep_step;
        logic res_set;
        res_t res_sel;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic div_done;
        logic at_nil;
        logic key_match;
        logic free_empty;
        logic sweep_last;
    } sts_t;

endpackage

@@ hw/rtl/chm_div.sv @@
// ----------------------------------------------------------------------------
// chm_div
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit
// divisor, quotient and remainder held after the done pulse.
// ----------------------------------------------------------------------------
module chm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [chm_pkg::DIV_W-1:0]     dividend,
    input  logic [chm_pkg::DVS_W-1:0]     divisor,
    output logic [chm_pkg::DIV_W-1:0]     quotient,
    output logic [chm_pkg::DVS_W-1:0]     remainder,
    output logic                          done
);

    logic [chm_pkg::DIV_W-1:0]     quo_reg;
    logic [chm_pkg::DVS_W-1:0]     rem_reg;
    logic [chm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          run_reg;
    logic                          done_reg;
    logic [chm_pkg::DVS_W:0]       trial;
    logic [chm_pkg::DVS_W:0]       diff;
    logic                          ge;

    // one trial subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[chm_pkg::DIV_W-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= chm_pkg::DIV_CNT_W'(chm_pkg::DIV_W);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == chm_pkg::DIV_CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // shift and subtract
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[chm_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[chm_pkg::DVS_W-1:0] : trial[chm_pkg::DVS_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

@@ hw/rtl/chm_datapath.sv @@
// ----------------------------------------------------------------------------
// chm_datapath
// Bucket head and entry pool memories, chain walk registers, free list,
// hash divider, configuration registers and the result register.
// ----------------------------------------------------------------------------
module chm_datapath #(
    parameter int MAX_BUCKETS  = chm_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_ENTRIES = chm_pkg::DEF_POOL_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  chm_pkg::ctl_t                   ctl,
    output chm_pkg::sts_t                   sts,
    input  logic [chm_pkg::CMD_W-1:0]       command,
    input  logic [chm_pkg::KEY_W-1:0]       key,
    input  logic [chm_pkg::HANDLE_W-1:0]    value_handle,
    input  logic [chm_pkg::LEVEL_W-1:0]     value_level,
    input  logic [chm_pkg::HANDLE_W-1:0]    default_handle,
    input  logic [chm_pkg::LEVEL_W-1:0]     default_level,
    input  logic                            cfg_we,
    input  logic [chm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [chm_pkg::CFG_W-1:0]       cfg_data,
    output logic                            done,
    output logic                            found,
    output logic [chm_pkg::HANDLE_W-1:0]    result_handle,
    output logic [chm_pkg::LEVEL_W-1:0]     result_level,
    output logic                            status
);

    localparam int PTR_W = $clog2(POOL_ENTRIES + 1);
    localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SW_N  = (MAX_BUCKETS > POOL_ENTRIES) ? MAX_BUCKETS : POOL_ENTRIES;
    localparam int SW_W  = (SW_N > 1) ? $clog2(SW_N) : 1;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

    // memories
    logic [PTR_W-1:0]            head_mem [MAX_BUCKETS];
    logic [chm_pkg::KEY_W-1:0]   key_mem  [POOL_ENTRIES];
    logic [chm_pkg::HANDLE_W-1:0] hnd_mem [POOL_ENTRIES];
    logic [chm_pkg::LEVEL_W-1:0] lvl_mem  [POOL_ENTRIES];
    logic [PTR_W-1:0]            link_mem [POOL_ENTRIES];

    // registers
    chm_pkg::cmd_t               cmd_reg;
    logic [chm_pkg::KEY_W-1:0]   key_reg;
    logic [chm_pkg::HANDLE_W-1:0] vh_reg;
    logic [chm_pkg::LEVEL_W-1:0] vl_reg;
    logic [chm_pkg::HANDLE_W-1:0] dh_reg;
    logic [chm_pkg::LEVEL_W-1:0] dl_reg;
    logic [BKT_W-1:0]            bucket_reg;
    logic [PTR_W-1:0]            head_reg;
    logic [PTR_W-1:0]            cur_reg;
    logic [PTR_W-1:0]            prev_reg;
    logic [PTR_W-1:0]            steps_reg;
    logic [PTR_W-1:0]            free_head_reg;
    logic [SW_W-1:0]             sw_reg;
    logic [chm_pkg::BC_W-1:0]    bc_reg;
    logic [chm_pkg::IV_W-1:0]    iv_reg;
    logic [PTR_W-1:0]            head_rd_reg;
    logic [chm_pkg::KEY_W-1:0]   key_rd_reg;
    logic [chm_pkg::HANDLE_W-1:0] hnd_rd_reg;
    logic [chm_pkg::LEVEL_W-1:0] lvl_rd_reg;
    logic [PTR_W-1:0]            link_rd_reg;
    logic                        done_reg;
    logic                        found_reg;
    logic [chm_pkg::HANDLE_W-1:0] rh_reg;
    logic [chm_pkg::LEVEL_W-1:0] rl_reg;
    logic                        status_reg;

    // divider hookup
    logic [chm_pkg::DIV_W-1:0]   div_dividend;
    logic [chm_pkg::DVS_W-1:0]   div_divisor;
    logic [chm_pkg::DIV_W-1:0]   div_quo;
    logic [chm_pkg::DVS_W-1:0]   div_rem;
    logic                        div_done;
    logic [chm_pkg::BC_W-1:0]    bc_eff;
    logic [chm_pkg::IV_W-1:0]    iv_eff;

    // memory write ports
    logic                        head_we;
    logic [BKT_W-1:0]            head_wa;
    logic [PTR_W-1:0]            head_wd;
    logic                        link_we;
    logic [IDX_W-1:0]            link_wa;
    logic [PTR_W-1:0]            link_wd;
    logic [IDX_W-1:0]            link_ra;
    logic                        val_we;
    logic [IDX_W-1:0]            val_wa;
    logic                        sw_in_heads;
    logic                        sw_in_pool;

    // effective hash operands
    always_comb
    begin
        if (bc_reg == '0)
            bc_eff = chm_pkg::BC_W'(1);
        else if ({21'b0, bc_reg} > 32'(MAX_BUCKETS))
            bc_eff = chm_pkg::BC_W'(MAX_BUCKETS);
        else
            bc_eff = bc_reg;
        iv_eff = (iv_reg == '0) ? chm_pkg::IV_W'(1) : iv_reg;
        if (ctl.div_sel)
        begin
            div_dividend = div_quo + chm_pkg::HASH_OFFSET;
            div_divisor  = {21'b0, bc_eff};
        end
        else
        begin
            div_dividend = {1'b0, key};
            div_divisor  = iv_eff;
        end
    end

    chm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (ctl.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // status to the controller
    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.div_done   = div_done;
        sts.at_nil     = (cur_reg >= NIL) || (steps_reg >= NIL);
        sts.key_match  = (key_rd_reg == key_reg);
        sts.free_empty = (free_head_reg >= NIL);
        sts.sweep_last = (sw_reg == SW_W'(SW_N - 1));
    end

    // memory write selection
    always_comb
    begin
        sw_in_heads = ({1'b0, sw_reg} < (SW_W + 1)'(MAX_BUCKETS));
        sw_in_pool  = ({1'b0, sw_reg} < (SW_W + 1)'(POOL_ENTRIES));
        head_we = 1'b0;
        head_wa = bucket_reg;
        head_wd = free_head_reg;
        link_we = 1'b0;
        link_wa = free_head_reg[IDX_W-1:0];
        link_wd = head_reg;
        if (ctl.sweep_step)
        begin
            head_we = sw_in_heads;
            head_wa = BKT_W'(sw_reg);
            head_wd = NIL;
            link_we = sw_in_pool;
            link_wa = IDX_W'(sw_reg);
            link_wd = PTR_W'(sw_reg) + PTR_W'(1);
        end
        else if (ctl.ins_write)
        begin
            head_we = 1'b1;
            link_we = 1'b1;
        end
        else if (ctl.unlink)
        begin
            if (prev_reg >= NIL)
            begin
                head_we = 1'b1;
                head_wd = link_rd_reg;
            end
            else
            begin
                link_we = 1'b1;
                link_wa = prev_reg[IDX_W-1:0];
                link_wd = link_rd_reg;
            end
        end
        else if (ctl.release_ent)
        begin
            link_we = 1'b1;
            link_wa = cur_reg[IDX_W-1:0];
            link_wd = free_head_reg;
        end
        link_ra = ctl.free_rd ? free_head_reg[IDX_W-1:0] : cur_reg[IDX_W-1:0];
        val_we  = ctl.ins_write || ctl.upd_write;
        val_wa  = ctl.ins_write ? free_head_reg[IDX_W-1:0] : cur_reg[IDX_W-1:0];
    end

    // bucket head memory
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        if (ctl.head_rd)
            head_rd_reg <= head_mem[bucket_reg];
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_wa] <= link_wd;
        if (ctl.ent_rd || ctl.free_rd)
            link_rd_reg <= link_mem[link_ra];
    end

    // key, handle and level memories
    always_ff @(posedge clk)
    begin
        if (ctl.ins_write)
            key_mem[val_wa] <= key_reg;
        if (val_we)
        begin
            hnd_mem[val_wa] <= vh_reg;
            lvl_mem[val_wa] <= vl_reg;
        end
        if (ctl.ent_rd)
        begin
            key_rd_reg <= key_mem[cur_reg[IDX_W-1:0]];
            hnd_rd_reg <= hnd_mem[cur_reg[IDX_W-1:0]];
            lvl_rd_reg <= lvl_mem[cur_reg[IDX_W-1:0]];
        end
    end

    // item capture and chain walk
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= chm_pkg::cmd_t'(command);
            key_reg <= key;
            vh_reg  <= value_handle;
            vl_reg  <= value_level;
            dh_reg  <= default_handle;
            dl_reg  <= default_level;
        end
        if (ctl.bucket_save)
            bucket_reg <= BKT_W'(div_rem);
        if (ctl.head_load)
        begin
            head_reg  <= head_rd_reg;
            cur_reg   <= head_rd_reg;
            prev_reg  <= NIL;
            steps_reg <= '0;
        end
        else if (ctl.adv)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= link_rd_reg;
            steps_reg <= steps_reg + 1'b1;
        end
    end

    // free list head, sweep counter and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            sw_reg        <= '0;
            bc_reg        <= chm_pkg::BC_RESET;
            iv_reg        <= chm_pkg::IV_RESET;
        end
        else
        begin
            if (ctl.capture)
                sw_reg <= '0;
            else if (ctl.sweep_step)
                sw_reg <= sw_reg + 1'b1;
            if (ctl.sweep_step)
                free_head_reg <= '0;
            else if (ctl.ins_write)
                free_head_reg <= link_rd_reg;
            else if (ctl.release_ent)
                free_head_reg <= cur_reg;
            if (cfg_we)
            begin
                unique case (chm_pkg::cfg_idx_t'(cfg_index))
                    chm_pkg::CFG_BUCKET_COUNT: bc_reg <= cfg_data[chm_pkg::BC_W-1:0];
                    chm_pkg::CFG_KEY_INTERVAL: iv_reg <= cfg_data[chm_pkg::IV_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl.res_set;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctl.res_set)
        begin
            found_reg  <= 1'b0;
            rh_reg     <= '0;
            rl_reg     <= '0;
            status_reg <= 1'b0;
            case (ctl.res_sel)
                chm_pkg::RES_VALUE:
                begin
                    found_reg <= 1'b1;
                    rh_reg    <= hnd_rd_reg;
                    rl_reg    <= lvl_rd_reg;
                end
                chm_pkg::RES_DEFAULT:
                begin
                    rh_reg <= dh_reg;
                    rl_reg <= dl_reg;
                end
                chm_pkg::RES_FOUND: found_reg  <= 1'b1;
                chm_pkg::RES_FULL:  status_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign done          = done_reg;
    assign found         = found_reg;
    assign result_handle = rh_reg;
    assign result_level  = rl_reg;
    assign status        = status_reg;

endmodule

@@ hw/rtl/chm_ctrl.sv @@
// ----------------------------------------------------------------------------
// chm_ctrl
// Sequencer for one command: hash by two divider passes, read the bucket
// head, walk the chain, then update, insert or unlink; clear only sweeps.
// ----------------------------------------------------------------------------
module chm_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [chm_pkg::CMD_W-1:0] command,
    output logic                      busy,
    input  chm_pkg::sts_t             sts,
    output chm_pkg::ctl_t             ctl
);

    chm_pkg::state_t state_reg;
    chm_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= chm_pkg::ST_INIT;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        ctl.res_sel = chm_pkg::RES_NONE;
        unique case (state_reg)
            chm_pkg::ST_INIT:
            begin
                ctl.sweep_step = 1'b1;
                if (sts.sweep_last)
                    state_next = chm_pkg::ST_IDLE;
            end
            chm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    if (chm_pkg::cmd_t'(command) == chm_pkg::CMD_CLEAR)
                        state_next = chm_pkg::ST_SWEEP;
                    else
                    begin
                        ctl.div_start = 1'b1;
                        state_next    = chm_pkg::ST_DIVQ;
                    end
                end
            end
            chm_pkg::ST_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    ctl.res_set = 1'b1;
                    state_next  = chm_pkg::ST_IDLE;
                end
            end
            chm_pkg::ST_DIVQ:
            begin
                if (sts.div_done)
                begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = 1'b1;
                    state_next    = chm_pkg::ST_DIVR;
                end
            end
            chm_pkg::ST_DIVR:
            begin
                ctl.div_sel = 1'b1;
                if (sts.div_done)
                begin
                    ctl.bucket_save = 1'b1;
                    state_next      = chm_pkg::ST_HEAD;
                end
            end
            chm_pkg::ST_HEAD:
            begin
                ctl.head_rd = 1'b1;
                state_next  = chm_pkg::ST_HEADW;
            end
            chm_pkg::ST_HEADW:
            begin
                ctl.head_load = 1'b1;
                state_next    = chm_pkg::ST_WALK;
            end
            chm_pkg::ST_WALK:
            begin
                if (sts.at_nil)
                begin
                    // key absent
                    if (sts.cmd == chm_pkg::CMD_SET && !sts.free_empty)
                    begin
                        ctl.free_rd = 1'b1;
                        state_next  = chm_pkg::ST_INSERT;
                    end
                    else
                    begin
                        ctl.res_set = 1'b1;
                        if (sts.cmd == chm_pkg::CMD_LOOKUP)
                            ctl.res_sel = chm_pkg::RES_DEFAULT;
                        else if (sts.cmd == chm_pkg::CMD_SET)
                            ctl.res_sel = chm_pkg::RES_FULL;
                        state_next = chm_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    ctl.ent_rd = 1'b1;
                    state_next = chm_pkg::ST_CMP;
                end
            end
            chm_pkg::ST_CMP:
            begin
                if (sts.key_match)
                begin
                    if (sts.cmd == chm_pkg::CMD_DELETE)
                    begin
                        ctl.unlink = 1'b1;
                        state_next = chm_pkg::ST_RELEASE;
                    end
                    else
                    begin
                        ctl.res_set   = 1'b1;
                        ctl.upd_write = (sts.cmd == chm_pkg::CMD_SET);
                        ctl.res_sel   = (sts.cmd == chm_pkg::CMD_SET) ?
                                        chm_pkg::RES_FOUND : chm_pkg::RES_VALUE;
                        state_next    = chm_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    ctl.adv    = 1'b1;
                    state_next = chm_pkg::ST_WALK;
                end
            end
            chm_pkg::ST_INSERT:
            begin
                ctl.ins_write = 1'b1;
                ctl.res_set   = 1'b1;
                state_next    = chm_pkg::ST_IDLE;
            end
            chm_pkg::ST_RELEASE:
            begin
                ctl.release_ent = 1'b1;
                ctl.res_set     = 1'b1;
                ctl.res_sel     = chm_pkg::RES_FOUND;
                state_next      = chm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = chm_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != chm_pkg::ST_IDLE);

    // an accepted command always leaves idle
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chm_pkg::ST_IDLE && start) |=> state_reg != chm_pkg::ST_IDLE)
        else $error("accepted item did not start work");

    // an insert only takes an entry from a non-empty free list
    a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins_write |-> ($past(ctl.free_rd) && !sts.free_empty))
        else $error("insert without free entry");

    // a released entry was unlinked the cycle before
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.release_ent |-> $past(ctl.unlink))
        else $error("release without unlink");

    // the bucket is taken only when the modulo pass finishes
    a_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.bucket_save |-> (sts.div_done && state_reg == chm_pkg::ST_DIVR))
        else $error("bucket saved outside modulo pass");

endmodule

@@ hw/rtl/chained_hash_map_engine.sv @@
// ----------------------------------------------------------------------------
// chained_hash_map_engine
// Key-value map with separate chaining over a fixed entry pool: lookup, set,
// delete and clear, one command at a time.
// ----------------------------------------------------------------------------
// operation: two divider passes (key / interval, then that quotient plus a
//   fixed offset mod bucket count), one head read, then a walk of the chain
//   entry by entry; an insert then writes the new entry in its own state;
//   clear sweeps every bucket and entry and rebuilds the free list
// throughput: one item at a time, busy stays high until done strobes
// reset: a sweep empties the buckets and rebuilds the free list; busy is
//   high meanwhile; done can't be stalled
module chained_hash_map_engine #(
    parameter int MAX_BUCKETS  = chm_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_ENTRIES = chm_pkg::DEF_POOL_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [chm_pkg::CMD_W-1:0]       command,
    input  logic [chm_pkg::KEY_W-1:0]       key,
    input  logic [chm_pkg::HANDLE_W-1:0]    value_handle,
    input  logic [chm_pkg::LEVEL_W-1:0]     value_level,
    input  logic [chm_pkg::HANDLE_W-1:0]    default_handle,
    input  logic [chm_pkg::LEVEL_W-1:0]     default_level,
    output logic                            done,
    output logic                            found,
    output logic [chm_pkg::HANDLE_W-1:0]    result_handle,
    output logic [chm_pkg::LEVEL_W-1:0]     result_level,
    output logic                            status,
    input  logic                            cfg_we,
    input  logic [chm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [chm_pkg::CFG_W-1:0]       cfg_data
);

    chm_pkg::ctl_t ctl;
    chm_pkg::sts_t sts;

    // sequencer
    chm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .sts     (sts),
        .ctl     (ctl)
    );

    // tables, walk registers and result
    chm_datapath #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .command        (command),
        .key            (key),
        .value_handle   (value_handle),
        .value_level    (value_level),
        .default_handle (default_handle),
        .default_level  (default_level),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .found          (found),
        .result_handle  (result_handle),
        .result_level   (result_level),
        .status         (status)
    );

endmodule
